### src/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge outside reset.
`define LVC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("lvc assertion failed");

// Checked at every edge, reset included.
`define LVC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("lvc assertion failed");

`endif

### src/lvc_pkg.sv
// Shared constants, codes and command types of the cache hierarchy.
package lvc_pkg;
    localparam int L1_SETS     = 16;
    localparam int L2_SETS     = 16;
    localparam int L2_WAYS     = 8;
    localparam int VIC_ENTRIES = 4;
    localparam int IDX_W   = 4;
    localparam int TAG_W   = 26;
    localparam int VTAG_W  = 30;
    localparam int WORD_W  = 32;
    localparam int ADDR_W  = 32;
    localparam int CNT_W   = 32;
    localparam int N_CNT   = 6;
    localparam int VIC_W   = $clog2(VIC_ENTRIES);
    localparam int WAY_W   = $clog2(L2_WAYS);
    localparam int L2ENT_W = TAG_W + WORD_W;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [1:0] {
        LVL_L1   = 2'd0,
        LVL_VIC  = 2'd1,
        LVL_L2   = 2'd2,
        LVL_MISS = 2'd3
    } t_level;

    typedef struct packed {
        logic capture;
        logic look;
        logic upd1;
        logic upd2;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic need_upd2;
        logic out_free;
    } t_sts;
endpackage

### src/lvc_if.sv
// Request and response channel interfaces.
interface lvc_req_if;
    logic                      valid;
    logic                      ready;
    logic                      opcode;
    logic [lvc_pkg::ADDR_W-1:0] address;
    logic signed [lvc_pkg::WORD_W-1:0] write_data;
    logic signed [lvc_pkg::WORD_W-1:0] mem_data;
    modport source (output valid, opcode, address, write_data, mem_data, input ready);
    modport sink   (input valid, opcode, address, write_data, mem_data, output ready);
endinterface

interface lvc_rsp_if;
    logic                      valid;
    logic                      ready;
    logic signed [lvc_pkg::WORD_W-1:0] read_data;
    logic [1:0]                hit_level;
    logic                      write_through;
    logic [lvc_pkg::CNT_W-1:0] l1_accesses;
    logic [lvc_pkg::CNT_W-1:0] l1_misses;
    logic [lvc_pkg::CNT_W-1:0] victim_accesses;
    logic [lvc_pkg::CNT_W-1:0] victim_misses;
    logic [lvc_pkg::CNT_W-1:0] l2_accesses;
    logic [lvc_pkg::CNT_W-1:0] l2_misses;
    modport source (output valid, read_data, hit_level, write_through, l1_accesses,
                    l1_misses, victim_accesses, victim_misses, l2_accesses, l2_misses,
                    input ready);
    modport sink   (input valid, read_data, hit_level, write_through, l1_accesses,
                    l1_misses, victim_accesses, victim_misses, l2_accesses, l2_misses,
                    output ready);
endinterface

### src/lvc_ctrl.sv
// Sequencing state machine of the cache hierarchy.
module lvc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lvc_pkg::t_sts i_sts,
    output lvc_pkg::t_cmd o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOOK = 5'b00010,
        S_UPD1 = 5'b00100,
        S_UPD2 = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) n_state = S_LOOK;
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = S_UPD1;
            end
            S_UPD1: begin
                o_cmd.upd1 = 1'b1;
                n_state    = i_sts.need_upd2 ? S_UPD2 : S_DONE;
            end
            S_UPD2: begin
                o_cmd.upd2 = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

### src/lvc_dp.sv
// Datapath: L1, victim cache, L2 storage, LRU ranks, counters and result word.
module lvc_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lvc_pkg::t_cmd i_cmd,
    output lvc_pkg::t_sts o_sts,
    lvc_req_if.sink       i_req,
    lvc_rsp_if.source     o_rsp
);
    localparam int IW = lvc_pkg::IDX_W;
    localparam int TW = lvc_pkg::TAG_W;
    localparam int DW = lvc_pkg::WORD_W;
    localparam int VN = lvc_pkg::VIC_ENTRIES;
    localparam int WN = lvc_pkg::L2_WAYS;
    localparam int SN = lvc_pkg::L2_SETS;
    localparam int VW = lvc_pkg::VIC_W;
    localparam int WW = lvc_pkg::WAY_W;
    localparam int CW = lvc_pkg::CNT_W;

    // captured request
    logic          r_op;
    logic [31:0]   r_addr;
    logic [DW-1:0] r_wdata, r_mdata;
    logic [IW-1:0] idx;
    logic [TW-1:0] tag;
    logic [lvc_pkg::VTAG_W-1:0] vtag;

    // storage
    logic          r_l1_valid [lvc_pkg::L1_SETS];
    logic [TW-1:0] r_l1_tag   [lvc_pkg::L1_SETS];
    logic [DW-1:0] r_l1_word  [lvc_pkg::L1_SETS];
    logic          r_v_valid  [VN];
    logic [VW-1:0] r_v_rank   [VN];
    logic [lvc_pkg::VTAG_W-1:0] r_v_tag [VN];
    logic [DW-1:0] r_v_word   [VN];
    logic          r_l2_valid [SN][WN];
    logic [WW-1:0] r_l2_rank  [SN][WN];
    logic [lvc_pkg::L2ENT_W-1:0] m_l2 [WN][SN];
    logic [lvc_pkg::L2ENT_W-1:0] r_l2_rd [WN];
    logic [CW-1:0] r_cnt [lvc_pkg::N_CNT];

    // lookup results
    lvc_pkg::t_level r_level;
    logic [VW-1:0] r_vpos, r_vp;
    logic [WW-1:0] r_wpos, r_lp;
    logic [IW-1:0] r_ls;
    logic          r_vev, r_ovalid, r_need2;
    logic [TW-1:0] r_hit_tag, r_otag, r_etag;
    logic [DW-1:0] r_hit_word, r_oword, r_eword;

    // result word
    logic [DW-1:0] r_res_rdata;
    lvc_pkg::t_level r_res_level;
    logic          r_o_valid;
    logic [DW-1:0] r_o_rdata;
    logic [1:0]    r_o_level;
    logic          r_o_wt;
    logic [CW-1:0] r_o_cnt [lvc_pkg::N_CNT];

    assign idx  = r_addr[5:2];
    assign tag  = r_addr[31:6];
    assign vtag = r_addr[31:2];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_req.opcode;
            r_addr  <= i_req.address;
            r_wdata <= i_req.write_data;
            r_mdata <= i_req.mem_data;
        end
    end

    // lookup
    logic            l1_hit, v_hit, w_hit, v_found, w_found;
    lvc_pkg::t_level lk_level;
    logic [VW-1:0]   lk_vpos, lk_vp;
    logic [WW-1:0]   lk_wpos, lk_lp;
    logic            lk_vev;
    logic [IW-1:0]   lk_ls;

    always_comb begin
        v_hit = 1'b0; lk_vpos = '0;
        for (int i = 0; i < VN; i++) begin
            if (!v_hit && r_v_valid[i] && r_v_tag[i] == vtag) begin
                v_hit = 1'b1; lk_vpos = VW'(i);
            end
        end
        w_hit = 1'b0; lk_wpos = '0;
        for (int i = 0; i < WN; i++) begin
            if (!w_hit && r_l2_valid[idx][i] && r_l2_rd[i][lvc_pkg::L2ENT_W-1:DW] == tag) begin
                w_hit = 1'b1; lk_wpos = WW'(i);
            end
        end
        l1_hit = r_l1_valid[idx] && r_l1_tag[idx] == tag;
        if (l1_hit)      lk_level = lvc_pkg::LVL_L1;
        else if (v_hit)  lk_level = lvc_pkg::LVL_VIC;
        else if (w_hit)  lk_level = lvc_pkg::LVL_L2;
        else             lk_level = lvc_pkg::LVL_MISS;

        v_found = 1'b0; lk_vp = VW'(VN - 1); lk_vev = 1'b1;
        for (int i = 0; i < VN; i++) begin
            if (!v_found && (!r_v_valid[i] || r_v_rank[i] == '0)) begin
                v_found = 1'b1; lk_vp = VW'(i); lk_vev = r_v_valid[i];
            end
        end
        lk_ls = r_v_tag[lk_vp][IW-1:0];
        w_found = 1'b0; lk_lp = WW'(WN - 1);
        for (int i = 0; i < WN; i++) begin
            if (!w_found && (!r_l2_valid[lk_ls][i] || r_l2_rank[lk_ls][i] == '0)) begin
                w_found = 1'b1; lk_lp = WW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.look) begin
            r_level  <= lk_level;
            r_vpos   <= lk_vpos;
            r_wpos   <= lk_wpos;
            r_vp     <= lk_vp;
            r_vev    <= lk_vev;
            r_ls     <= lk_ls;
            r_lp     <= lk_lp;
            r_ovalid <= r_l1_valid[idx];
            r_otag   <= r_l1_tag[idx];
            r_oword  <= r_l1_word[idx];
            r_etag   <= r_v_tag[lk_vp][lvc_pkg::VTAG_W-1:IW];
            r_eword  <= r_v_word[lk_vp];
            if (v_hit) begin
                r_hit_tag  <= r_v_tag[lk_vpos][lvc_pkg::VTAG_W-1:IW];
                r_hit_word <= r_v_word[lk_vpos];
            end else begin
                r_hit_tag  <= r_l2_rd[lk_wpos][lvc_pkg::L2ENT_W-1:DW];
                r_hit_word <= r_l2_rd[lk_wpos][DW-1:0];
            end
            r_need2 <= (r_op == lvc_pkg::OP_READ) && r_l1_valid[idx] && lk_vev &&
                       (lk_level == lvc_pkg::LVL_L2 || lk_level == lvc_pkg::LVL_MISS);
        end
    end

    // victim rank update
    logic          rd_op, spill1;
    logic          v_do;
    logic [VW-1:0] v_p, v_old;
    always_comb begin
        rd_op  = r_op == lvc_pkg::OP_READ;
        spill1 = rd_op && r_ovalid &&
                 (r_level == lvc_pkg::LVL_L2 || r_level == lvc_pkg::LVL_MISS);
        v_do = 1'b0; v_p = r_vpos; v_old = '0;
        if (r_level == lvc_pkg::LVL_VIC) begin
            v_do  = 1'b1;
            v_old = (!rd_op || r_ovalid) ? r_v_rank[r_vpos] : '0;
        end else if (spill1) begin
            v_do  = 1'b1;
            v_p   = r_vp;
            v_old = r_v_valid[r_vp] ? r_v_rank[r_vp] : '0;
        end
    end

    // L2 rank update: free on a read hit, promote on a write hit or a spill
    logic          l2_do, l2_free, l2_we;
    logic [IW-1:0] l2_s;
    logic [WW-1:0] l2_w, l2_old;
    logic [lvc_pkg::L2ENT_W-1:0] l2_wdata;
    always_comb begin
        l2_do = 1'b0; l2_free = 1'b0; l2_we = 1'b0;
        l2_s = idx; l2_w = r_wpos;
        l2_wdata = {r_hit_tag, r_wdata};
        if (i_cmd.upd1 && r_level == lvc_pkg::LVL_L2) begin
            l2_do   = 1'b1;
            l2_free = rd_op;
            l2_we   = !rd_op;
        end else if (i_cmd.upd2) begin
            l2_do = 1'b1; l2_we = 1'b1;
            l2_s = r_ls; l2_w = r_lp;
            l2_wdata = {r_etag, r_eword};
        end
        l2_old = (l2_free || r_l2_valid[l2_s][l2_w]) ? r_l2_rank[l2_s][l2_w] : '0;
    end

    always_ff @(posedge i_clk) begin
        for (int w = 0; w < WN; w++) begin
            if (l2_we && l2_w == WW'(w)) m_l2[w][l2_s] <= l2_wdata;
            r_l2_rd[w] <= m_l2[w][i_cmd.capture ? i_req.address[5:2] : idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lvc_pkg::L1_SETS; i++) r_l1_valid[i] <= 1'b0;
            for (int i = 0; i < VN; i++) begin
                r_v_valid[i] <= 1'b0;
                r_v_rank[i]  <= '0;
            end
            for (int s = 0; s < SN; s++) begin
                for (int w = 0; w < WN; w++) begin
                    r_l2_valid[s][w] <= 1'b0;
                    r_l2_rank[s][w]  <= '0;
                end
            end
            for (int i = 0; i < lvc_pkg::N_CNT; i++) r_cnt[i] <= '0;
        end else begin
            if (i_cmd.upd1) begin
                if (rd_op) begin
                    r_cnt[0] <= r_cnt[0] + 1'b1;
                    if (r_level != lvc_pkg::LVL_L1) begin
                        r_cnt[1] <= r_cnt[1] + 1'b1;
                        r_cnt[2] <= r_cnt[2] + 1'b1;
                    end
                    if (r_level == lvc_pkg::LVL_L2 || r_level == lvc_pkg::LVL_MISS) begin
                        r_cnt[3] <= r_cnt[3] + 1'b1;
                        r_cnt[4] <= r_cnt[4] + 1'b1;
                    end
                    if (r_level == lvc_pkg::LVL_MISS) r_cnt[5] <= r_cnt[5] + 1'b1;
                    if (r_level != lvc_pkg::LVL_L1) begin
                        r_l1_valid[idx] <= 1'b1;
                        r_l1_tag[idx]   <= (r_level == lvc_pkg::LVL_MISS) ? tag : r_hit_tag;
                        r_l1_word[idx]  <= (r_level == lvc_pkg::LVL_MISS) ? r_mdata
                                                                          : r_hit_word;
                    end
                    if (r_level == lvc_pkg::LVL_VIC) begin
                        r_v_valid[r_vpos] <= r_ovalid;
                        r_v_tag[r_vpos]   <= {r_otag, idx};
                        r_v_word[r_vpos]  <= r_oword;
                    end else if (spill1) begin
                        r_v_valid[r_vp] <= 1'b1;
                        r_v_tag[r_vp]   <= {r_otag, idx};
                        r_v_word[r_vp]  <= r_oword;
                    end
                end else begin
                    if (r_level == lvc_pkg::LVL_L1)  r_l1_word[idx]  <= r_wdata;
                    if (r_level == lvc_pkg::LVL_VIC) r_v_word[r_vpos] <= r_wdata;
                end
                if (v_do) begin
                    for (int i = 0; i < VN; i++) begin
                        if (VW'(i) == v_p)          r_v_rank[i] <= VW'(VN - 1);
                        else if (r_v_rank[i] > v_old) r_v_rank[i] <= r_v_rank[i] - 1'b1;
                    end
                end
            end
            if (l2_do) begin
                for (int w = 0; w < WN; w++) begin
                    if (l2_free) begin
                        if (r_l2_rank[l2_s][w] < l2_old)
                            r_l2_rank[l2_s][w] <= r_l2_rank[l2_s][w] + 1'b1;
                    end else if (WW'(w) == l2_w) begin
                        r_l2_rank[l2_s][w] <= WW'(WN - 1);
                    end else if (r_l2_rank[l2_s][w] > l2_old) begin
                        r_l2_rank[l2_s][w] <= r_l2_rank[l2_s][w] - 1'b1;
                    end
                end
                r_l2_valid[l2_s][l2_w] <= !l2_free;
            end
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd1) begin
            r_res_level <= r_level;
            if (!rd_op)                          r_res_rdata <= '0;
            else if (r_level == lvc_pkg::LVL_L1)   r_res_rdata <= r_l1_word[idx];
            else if (r_level == lvc_pkg::LVL_MISS) r_res_rdata <= r_mdata;
            else                                 r_res_rdata <= r_hit_word;
        end
        if (i_cmd.load_out) begin
            r_o_rdata <= r_res_rdata;
            r_o_level <= r_res_level;
            r_o_wt    <= r_op;
            for (int i = 0; i < lvc_pkg::N_CNT; i++) r_o_cnt[i] <= r_cnt[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_o_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_sts.out_free  = !r_o_valid || o_rsp.ready;
    assign o_sts.need_upd2 = r_need2;

    assign o_rsp.valid           = r_o_valid;
    assign o_rsp.read_data       = r_o_rdata;
    assign o_rsp.hit_level       = r_o_level;
    assign o_rsp.write_through   = r_o_wt;
    assign o_rsp.l1_accesses     = r_o_cnt[0];
    assign o_rsp.l1_misses       = r_o_cnt[1];
    assign o_rsp.victim_accesses = r_o_cnt[2];
    assign o_rsp.victim_misses   = r_o_cnt[3];
    assign o_rsp.l2_accesses     = r_o_cnt[4];
    assign o_rsp.l2_misses       = r_o_cnt[5];
endmodule

### src/l1_victim_l2_cache_hierarchy.sv
// Top level of the L1 / victim cache / L2 hierarchy.
// One request word (opcode, address, write_data, mem_data) on i_req gives
// one response word on o_rsp: read data, hit level, write-through flag and
// six running read counters.
// After a request is accepted, the controller steps through lookup and slot
// choice, the main update, the optional L2 write-back when a line evicted from
// the victim cache goes back to L2, then the load of the response register.
// The controller runs one request at a time and takes no new request before
// the last one is loaded into the response register.
// i_req.ready is high only while the controller is idle.
// A stalled response is held in the output register; the block finishes
// the next request's work up to the load and waits there for the receiver.
// Reset clears all valid bits, LRU ranks, counters and the response valid;
// tags and data are not cleared.
module l1_victim_l2_cache_hierarchy (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lvc_req_if.sink   i_req,
    lvc_rsp_if.source o_rsp
);
    lvc_pkg::t_cmd cmd;
    lvc_pkg::t_sts sts;

    lvc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lvc_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );
endmodule

### src/lvc_chk.sv
// Port-level checker for the cache hierarchy and its bind.
`include "assert_macros.svh"

module lvc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_rdata,
    input logic        i_wt
);
    `LVC_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid)
    `LVC_ASSERT(a_out_stable, i_out_valid && !i_out_ready |=> $stable(i_rdata))
    `LVC_ASSERT(a_one_at_a_time, i_in_valid && i_in_ready |=> !i_in_ready)
    `LVC_ASSERT(a_write_zero, i_out_valid && i_wt |-> i_rdata == 32'd0)
    `LVC_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> !i_out_valid)
endmodule

bind l1_victim_l2_cache_hierarchy lvc_chk u_lvc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_rdata     (o_rsp.read_data),
    .i_wt        (o_rsp.write_through)
);

### bench/lvc_checker.sv
// Checker for the cache hierarchy: watches both channels, predicts responses and compares them.
`timescale 1ns / 1ps
module lvc_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    lvc_req_if     req,
    lvc_rsp_if     rsp,
    output int     o_fail_count,
    output int     o_pending
);
    import lvc_pkg::*;

    typedef struct {
        logic [WORD_W-1:0] read_data;
        logic [1:0]        hit_level;
        logic              write_through;
        logic [CNT_W-1:0]  cnt [N_CNT];
    } t_expected;

    logic               l1_v    [L1_SETS];
    logic [TAG_W-1:0]   l1_t    [L1_SETS];
    logic [WORD_W-1:0]  l1_d    [L1_SETS];
    logic               vc_v    [VIC_ENTRIES];
    logic [VTAG_W-1:0]  vc_t    [VIC_ENTRIES];
    logic [WORD_W-1:0]  vc_d    [VIC_ENTRIES];
    int unsigned        vc_r    [VIC_ENTRIES];
    logic               l2_v    [L2_SETS][L2_WAYS];
    logic [TAG_W-1:0]   l2_t    [L2_SETS][L2_WAYS];
    logic [WORD_W-1:0]  l2_d    [L2_SETS][L2_WAYS];
    int unsigned        l2_r    [L2_SETS][L2_WAYS];
    logic [CNT_W-1:0]   counts  [N_CNT];

    t_expected          rsp_queue [$];

    function automatic void vc_touch(int p);
        int unsigned old;
        old = vc_v[p] ? vc_r[p] : 0;
        for (int i = 0; i < VIC_ENTRIES; i++)
            if (vc_r[i] > old) vc_r[i]--;
        vc_r[p] = VIC_ENTRIES - 1;
    endfunction

    function automatic void l2_touch(int s, int w);
        int unsigned old;
        old = l2_v[s][w] ? l2_r[s][w] : 0;
        for (int i = 0; i < L2_WAYS; i++)
            if (l2_r[s][i] > old) l2_r[s][i]--;
        l2_r[s][w] = L2_WAYS - 1;
    endfunction

    function automatic void l2_release(int s, int w);
        int unsigned old;
        old = l2_r[s][w];
        for (int i = 0; i < L2_WAYS; i++)
            if (l2_r[s][i] < old) l2_r[s][i]++;
        l2_v[s][w] = 1'b0;
    endfunction

    function automatic void predict_access(logic op, logic [ADDR_W-1:0] addr,
                                           logic [WORD_W-1:0] wd, logic [WORD_W-1:0] md);
        t_expected         e;
        int                idx, pos, vp, ls, lp;
        logic [TAG_W-1:0]  tg;
        logic [VTAG_W-1:0] vt, etag;
        logic [WORD_W-1:0] eword, oword;
        logic [TAG_W-1:0]  otag;
        logic              ovalid, vev, found;
        logic [1:0]        lvl;
        idx = addr[5:2];
        tg = addr[31:6];
        vt = addr[31:2];
        lvl = LVL_MISS;
        pos = 0;
        e.read_data = '0;
        if (l1_v[idx] && l1_t[idx] == tg) begin
            lvl = LVL_L1;
        end else begin
            for (int i = 0; i < VIC_ENTRIES && lvl == LVL_MISS; i++)
                if (vc_v[i] && vc_t[i] == vt) begin lvl = LVL_VIC; pos = i; end
            for (int i = 0; i < L2_WAYS && lvl == LVL_MISS; i++)
                if (l2_v[idx][i] && l2_t[idx][i] == tg) begin lvl = LVL_L2; pos = i; end
        end
        if (op == OP_READ) begin
            found = 1'b0;
            vev = 1'b1;
            vp = VIC_ENTRIES - 1;
            for (int i = 0; i < VIC_ENTRIES && !found; i++) begin
                if (vc_v[i] && vc_r[i] == 0) begin vp = i; vev = 1'b1; found = 1'b1; end
                else if (!vc_v[i]) begin vp = i; vev = 1'b0; found = 1'b1; end
            end
            ls = 0;
            lp = 0;
            if (vev) begin
                ls = vc_t[vp][3:0];
                found = 1'b0;
                lp = L2_WAYS - 1;
                for (int i = 0; i < L2_WAYS && !found; i++)
                    if (!l2_v[ls][i] || l2_r[ls][i] == 0) begin lp = i; found = 1'b1; end
            end
            ovalid = l1_v[idx];
            otag = l1_t[idx];
            oword = l1_d[idx];
            counts[0]++;
            if (lvl == LVL_L1) begin
                e.read_data = l1_d[idx];
            end else if (lvl == LVL_VIC) begin
                counts[1]++; counts[2]++;
                e.read_data = vc_d[pos];
                l1_v[idx] = 1'b1;
                l1_d[idx] = vc_d[pos];
                l1_t[idx] = vc_t[pos][29:4];
                vc_v[pos] = ovalid;
                vc_d[pos] = oword;
                vc_t[pos] = {otag, idx[3:0]};
                vc_touch(pos);
            end else begin
                if (lvl == LVL_L2) begin
                    counts[1]++; counts[2]++; counts[3]++; counts[4]++;
                    e.read_data = l2_d[idx][pos];
                    l1_d[idx] = l2_d[idx][pos];
                    l1_t[idx] = l2_t[idx][pos];
                    l2_release(idx, pos);
                end else begin
                    for (int i = 1; i < N_CNT; i++) counts[i]++;
                    e.read_data = md;
                    l1_t[idx] = tg;
                    l1_d[idx] = md;
                end
                l1_v[idx] = 1'b1;
                if (ovalid) begin
                    etag = vc_t[vp];
                    eword = vc_d[vp];
                    vc_touch(vp);
                    vc_v[vp] = 1'b1;
                    vc_t[vp] = {otag, idx[3:0]};
                    vc_d[vp] = oword;
                    if (vev) begin
                        l2_touch(ls, lp);
                        l2_v[ls][lp] = 1'b1;
                        l2_t[ls][lp] = etag[29:4];
                        l2_d[ls][lp] = eword;
                    end
                end
            end
        end else begin
            if (lvl == LVL_L1) l1_d[idx] = wd;
            else if (lvl == LVL_VIC) begin vc_d[pos] = wd; vc_touch(pos); end
            else if (lvl == LVL_L2) begin l2_d[idx][pos] = wd; l2_touch(idx, pos); end
        end
        e.hit_level = lvl;
        e.write_through = op;
        for (int i = 0; i < N_CNT; i++) e.cnt[i] = counts[i];
        rsp_queue.push_back(e);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_expected e;
        logic [CNT_W-1:0] g [N_CNT];
        if (!i_rst_n) begin
            for (int i = 0; i < L1_SETS; i++) l1_v[i] = 1'b0;
            for (int i = 0; i < VIC_ENTRIES; i++) begin vc_v[i] = 1'b0; vc_r[i] = 0; end
            for (int s = 0; s < L2_SETS; s++)
                for (int w = 0; w < L2_WAYS; w++) begin l2_v[s][w] = 1'b0; l2_r[s][w] = 0; end
            for (int i = 0; i < N_CNT; i++) counts[i] = '0;
            o_fail_count = 0;
        end else begin
            if (rsp.valid && rsp.ready) begin
                if (rsp_queue.size() == 0) begin
                    report_mismatch("unexpected word", 32'h0, 32'h0);
                end else begin
                    e = rsp_queue.pop_front();
                    g = '{rsp.l1_accesses, rsp.l1_misses, rsp.victim_accesses,
                          rsp.victim_misses, rsp.l2_accesses, rsp.l2_misses};
                    if (rsp.read_data !== e.read_data)
                        report_mismatch("read_data", rsp.read_data, e.read_data);
                    if (rsp.hit_level !== e.hit_level)
                        report_mismatch("hit_level", rsp.hit_level, e.hit_level);
                    if (rsp.write_through !== e.write_through)
                        report_mismatch("write_through", rsp.write_through, e.write_through);
                    for (int i = 0; i < N_CNT; i++)
                        if (g[i] !== e.cnt[i]) report_mismatch($sformatf("counter %0d", i),
                                                               g[i], e.cnt[i]);
                end
            end
            if (req.valid && req.ready)
                predict_access(req.opcode, req.address, req.write_data, req.mem_data);
        end
        o_pending = rsp_queue.size();
    end
endmodule

### bench/testbench.sv
// Stimulus, clock, reset and verdict for the cache hierarchy bench.
`timescale 1ns / 1ps
module testbench;
    import lvc_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count, pending, cycle_count = 0;
    logic calm = 1'b0;
    logic hold_rsp = 1'b0;

    lvc_req_if req ();
    lvc_rsp_if rsp ();

    l1_victim_l2_cache_hierarchy u_dut (.i_clk(i_clk), .i_rst_n(i_rst_n),
                                        .i_req(req), .o_rsp(rsp));
    lvc_checker u_chk (.i_clk(i_clk), .i_rst_n(i_rst_n), .req(req), .rsp(rsp),
                       .o_fail_count(fail_count), .o_pending(pending));

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > 200000) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: random stall bursts, or a long hold when asked
    initial begin
        int gap;
        rsp.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_rsp) begin
                rsp.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 3);
                rsp.ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                rsp.ready <= 1'b1;
            end
        end
    end

    // valid stays high between back-to-back words unless a random gap drops it outside calm mode; drain() drops it
    task automatic send_word(logic op, logic [31:0] addr, logic [31:0] wd, logic [31:0] md);
        if (!calm && $urandom_range(0, 4) == 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        req.valid <= 1'b1;
        req.opcode <= op;
        req.address <= addr;
        req.write_data <= wd;
        req.mem_data <= md;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    // addresses from a small pool so lines collide in L1, victim and L2
    function automatic logic [31:0] pool_addr();
        logic [31:0] a;
        a = {26'($urandom_range(0, 23)), 4'($urandom_range(0, 3)), 2'($urandom)};
        if ($urandom_range(0, 9) == 0) a = $urandom;
        return a;
    endfunction

    initial begin
        req.valid = 1'b0;
        req.opcode = OP_READ;
        req.address = '0;
        req.write_data = '0;
        req.mem_data = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        // directed: extremes, fills, L2 hits, writes in L1, in L2 and on a miss
        send_word(OP_READ, 32'h0, 32'h0, 32'h7fffffff);
        send_word(OP_READ, 32'hffffffff, 32'h0, 32'h80000000);
        send_word(OP_WRITE, 32'hffffffff, 32'hffffffff, 32'h0);
        send_word(OP_READ, 32'hfffffffc, 32'h0, 32'h0);
        send_word(OP_WRITE, 32'h12345678, 32'h5a5a5a5a, 32'h0);
        for (int k = 1; k <= 12; k++)
            send_word(OP_READ, {26'(k), 6'h0}, 32'h0, 32'(k * 32'h01010101));
        send_word(OP_READ, 32'h00000040, 32'h0, 32'h0);
        send_word(OP_WRITE, 32'h00000080, 32'haaaaaaaa, 32'h0);
        send_word(OP_WRITE, 32'h00000100, 32'h55555555, 32'h0);
        send_word(OP_READ, 32'h00000100, 32'h0, 32'h0);
        send_word(OP_READ, 32'h00000080, 32'h0, 32'h0);
        send_word(OP_READ, 32'h0, 32'h0, 32'h0);
        // long receiver hold while requests keep coming
        fork
            begin
                hold_rsp = 1'b1;
                repeat (60) @(negedge i_clk);
                hold_rsp = 1'b0;
            end
            for (int k = 0; k < 6; k++)
                send_word(1'($urandom_range(0, 1)), pool_addr(), $urandom, $urandom);
        join
        for (int n = 0; n < 400; n++) begin
            if (n == 200) drain();
            if (n == 340) calm = 1'b1;
            send_word($urandom_range(0, 3) == 0, pool_addr(), $urandom, $urandom);
        end
        drain();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
